[rtl/core/fdl_pkg.sv]
// Package: widths, register indexes, mode codes and reset values of the delay line.
`timescale 1ns / 1ps
`default_nettype none
package fdl_pkg;

  localparam int DEPTH_DEF       = 65536;
  localparam int SAMPLE_BITS_DEF = 24;

  localparam int TARGET_W = 33;
  localparam int RAMP_W   = 13;
  localparam int MODE_W   = 2;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_MODE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RAMP   = 2'd2;

  localparam logic [MODE_W-1:0] MODE_NONE   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_LINEAR = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CUBIC  = 2'd2;

  localparam logic [MODE_W-1:0]   MODE_RST   = MODE_CUBIC;
  localparam logic [TARGET_W-1:0] TARGET_RST = 33'd3145728000;
  localparam logic [RAMP_W-1:0]   RAMP_RST   = 13'd64;

endpackage
`default_nettype wire

[rtl/core/fractional_delay_line.sv]
// Fractional delay line: circular sample RAM read with none, linear or cubic interpolation.
// Sequence: an accepted input word goes through the target check, four tap reads and the
//   multiply steps of its mode to the output word; a target change adds one divider pass
//   for the glide step.
// Flow: a new input is taken only once the last result is on the output, where it may wait;
//   set by the single-port sample RAM (four tap reads) and the shared multiplier.
// Reset: rst_ni clears state, presets config registers; unwritten RAM entries read as zero.
`timescale 1ns / 1ps
`default_nettype none
module fractional_delay_line #(
  parameter int DEPTH       = fdl_pkg::DEPTH_DEF,
  parameter int SAMPLE_BITS = fdl_pkg::SAMPLE_BITS_DEF,
  localparam int TW         = ((SAMPLE_BITS + 7) / 8) * 8
) (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wire                            cfg_valid_i,
  output logic                           cfg_ready_o,
  input  wire  [fdl_pkg::CFG_IDX_W-1:0]  cfg_addr_i,
  input  wire  [fdl_pkg::TARGET_W-1:0]   cfg_data_i,
  input  wire                            s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  input  wire  [TW-1:0]                  s_axis_tdata_i,   // sample_in
  output logic                           m_axis_tvalid_o,
  input  wire                            m_axis_tready_i,
  output logic [TW-1:0]                  m_axis_tdata_o    // sample_out
);
  import fdl_pkg::*;

  localparam int SB   = SAMPLE_BITS;
  localparam int AW   = $clog2(DEPTH);
  localparam int IPW  = $clog2(DEPTH + 1);
  localparam int CDW  = IPW + 16;
  localparam int CMW  = (CDW > TARGET_W) ? CDW : TARGET_W;
  localparam int AGW  = IPW + 1;
  localparam int AXW  = AGW + 1;
  localparam int CNW  = $clog2(CDW + 1);
  localparam int OW   = SB + 6;
  localparam int PW   = OW + 17;

  localparam logic [CMW-1:0] LO_DLY = CMW'(65536);
  localparam logic [CMW-1:0] HI_DLY = CMW'(DEPTH) << 16;
  localparam logic [AGW-1:0] DEPTH_A = AGW'(DEPTH);
  localparam logic [AXW-1:0] DEPTH_X = AXW'(DEPTH);
  localparam logic signed [PW-1:0] HALF16 = PW'(32768);
  localparam logic signed [PW-1:0] HALF17 = PW'(65536);
  localparam logic signed [OW-1:0] MAXV = OW'((64'sd1 <<< (SB - 1)) - 64'sd1);
  localparam logic signed [OW-1:0] MINV = -MAXV - OW'(1);

  typedef enum logic [3:0] {
    ST_IDLE, ST_TGT, ST_DIV, ST_GLIDE, ST_RD, ST_M1, ST_L2, ST_C2, ST_C3, ST_C4, ST_OUT
  } state_e;

  function automatic logic [CDW-1:0] clamp_dly(input logic [TARGET_W-1:0] t);
    logic [CMW-1:0] tw;
    tw = CMW'(t);
    if (tw < LO_DLY) tw = LO_DLY;
    else if (tw > HI_DLY) tw = HI_DLY;
    return tw[CDW-1:0];
  endfunction

  function automatic logic signed [SB-1:0] sat(input logic signed [OW-1:0] v);
    logic signed [OW-1:0] r;
    r = v;
    if (v > MAXV) r = MAXV;
    else if (v < MINV) r = MINV;
    return r[SB-1:0];
  endfunction

  // configuration
  logic [MODE_W-1:0]   mode_q;
  logic [TARGET_W-1:0] target_q;
  logic [RAMP_W-1:0]   ramp_q;

  // delay state
  state_e                state_q;
  logic                  started_q;
  logic [TARGET_W-1:0]   last_q;
  logic [CDW-1:0]        cur_q;
  logic [RAMP_W-1:0]     glide_rem_q;
  logic [AW-1:0]         wp_q;
  logic                  wrapped_q;

  // glide-step divider
  logic [CDW-1:0]        div_num_q;
  logic [RAMP_W-1:0]     div_rem_q;
  logic [RAMP_W-1:0]     div_den_q;
  logic [CNW-1:0]        div_cnt_q;
  logic                  div_neg_q;

  // datapath
  logic signed [SB-1:0]  x_q;
  logic signed [SB-1:0]  taps_q [4];
  logic [2:0]            tap_cnt_q;
  logic                  tap_zero_q;
  logic                  tap_vld_q;
  logic                  rd_en;
  logic [AW-1:0]         rd_addr;
  logic signed [SB-1:0]  rd_data_q;
  logic signed [PW-1:0]  mul_q;
  logic signed [SB-1:0]  y_q;

  logic signed [SB-1:0]  mem [DEPTH];

  assign cfg_ready_o     = 1'b1;
  assign s_axis_tready_o = (state_q == ST_IDLE);

  // tap address
  logic [AGW-1:0] age, age_c;
  logic [AXW-1:0] adiff;
  logic           tap_zero, tap_vld;
  always_comb begin
    age   = AGW'(cur_q[CDW-1:16]) + AGW'(tap_cnt_q) - AGW'(1);
    age_c = (age > DEPTH_A) ? DEPTH_A : age;
    adiff = AXW'(wp_q) - AXW'(age_c);
    if (adiff[AXW-1]) adiff = adiff + DEPTH_X;
    rd_addr  = adiff[AW-1:0];
    tap_zero = (age == '0);
    tap_vld  = wrapped_q || (rd_addr < wp_q);
    rd_en    = (state_q == ST_RD) && (tap_cnt_q < 3'd4);
  end

  // glide arithmetic
  logic [CDW:0]          dtc, dmag;
  logic signed [CDW:0]   glide_step, cur_sum;
  logic [RAMP_W:0]       div_r;
  logic                  div_ge;
  logic [RAMP_W-1:0]     ramp_len;
  always_comb begin
    dtc        = {1'b0, clamp_dly(target_q)} - {1'b0, cur_q};
    dmag       = dtc[CDW] ? -dtc : dtc;
    ramp_len   = (ramp_q == '0) ? RAMP_W'(1) : ramp_q;
    div_r      = {div_rem_q, div_num_q[CDW-1]};
    div_ge     = (div_r >= {1'b0, div_den_q});
    glide_step = div_neg_q ? -$signed({1'b0, div_num_q}) : $signed({1'b0, div_num_q});
    cur_sum    = $signed({1'b0, cur_q}) + glide_step;
  end

  // interpolation arithmetic
  logic signed [OW-1:0] ym1, y0, y1, y2, c1, c2, c3, mul_a, a_v, b_v, lin_y, cub_y;
  logic signed [PW-1:0] prod, rnd16, rnd17;
  always_comb begin
    ym1   = OW'(taps_q[0]);
    y0    = OW'(taps_q[1]);
    y1    = OW'(taps_q[2]);
    y2    = OW'(taps_q[3]);
    c1    = y1 - ym1;
    c2    = (y1 <<< 2) + (ym1 <<< 1) - (y0 <<< 2) - y0 - y2;
    c3    = (y0 - y1) + (y0 - y1) + (y0 - y1) - ym1 + y2;
    rnd16 = (mul_q + HALF16) >>> 16;
    rnd17 = (mul_q + HALF17) >>> 17;
    a_v   = c2 + OW'(rnd16);
    b_v   = c1 + OW'(rnd16);
    lin_y = y0 + OW'(rnd16);
    cub_y = y0 + OW'(rnd17);
    unique case (state_q)
      ST_C2:   mul_a = a_v;
      ST_C3:   mul_a = b_v;
      default: mul_a = (mode_q == MODE_LINEAR) ? (y1 - y0) : c3;
    endcase
    prod = mul_a * $signed({1'b0, cur_q[15:0]});
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) rd_data_q <= mem[rd_addr];
    if (state_q == ST_OUT && (!m_axis_tvalid_o || m_axis_tready_i)) mem[wp_q] <= x_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q          <= MODE_RST;
      target_q        <= TARGET_RST;
      ramp_q          <= RAMP_RST;
      state_q         <= ST_IDLE;
      started_q       <= 1'b0;
      last_q          <= '0;
      cur_q           <= '0;
      glide_rem_q     <= '0;
      wp_q            <= '0;
      wrapped_q       <= 1'b0;
      div_num_q       <= '0;
      div_rem_q       <= '0;
      div_den_q       <= '0;
      div_cnt_q       <= '0;
      div_neg_q       <= 1'b0;
      x_q             <= '0;
      taps_q          <= '{default: '0};
      tap_cnt_q       <= '0;
      tap_zero_q      <= 1'b0;
      tap_vld_q       <= 1'b0;
      mul_q           <= '0;
      y_q             <= '0;
      m_axis_tvalid_o <= 1'b0;
      m_axis_tdata_o  <= '0;
    end else begin
      if (cfg_valid_i) begin
        unique case (cfg_addr_i)
          REG_MODE:   mode_q   <= cfg_data_i[MODE_W-1:0];
          REG_TARGET: target_q <= cfg_data_i;
          REG_RAMP:   ramp_q   <= cfg_data_i[RAMP_W-1:0];
          default: ;
        endcase
      end
      if (m_axis_tvalid_o && m_axis_tready_i && state_q != ST_OUT) m_axis_tvalid_o <= 1'b0;

      unique case (state_q)
        ST_IDLE: begin
          if (s_axis_tvalid_i) begin
            x_q     <= s_axis_tdata_i[SB-1:0];
            state_q <= ST_TGT;
          end
        end
        ST_TGT: begin
          if (!started_q) begin
            started_q   <= 1'b1;
            last_q      <= target_q;
            cur_q       <= clamp_dly(target_q);
            glide_rem_q <= '0;
            state_q     <= ST_GLIDE;
          end else if (target_q != last_q) begin
            div_num_q   <= dmag[CDW-1:0];
            div_neg_q   <= dtc[CDW];
            div_rem_q   <= '0;
            div_den_q   <= ramp_len;
            div_cnt_q   <= CNW'(CDW);
            glide_rem_q <= ramp_len;
            last_q      <= target_q;
            state_q     <= ST_DIV;
          end else begin
            state_q <= ST_GLIDE;
          end
        end
        ST_DIV: begin
          div_rem_q <= div_ge ? RAMP_W'(div_r - {1'b0, div_den_q}) : div_r[RAMP_W-1:0];
          div_num_q <= {div_num_q[CDW-2:0], div_ge};
          div_cnt_q <= div_cnt_q - CNW'(1);
          if (div_cnt_q == CNW'(1)) state_q <= ST_GLIDE;
        end
        ST_GLIDE: begin
          if (glide_rem_q != '0) begin
            if (glide_rem_q == RAMP_W'(1)) cur_q <= clamp_dly(last_q);
            else cur_q <= cur_sum[CDW-1:0];
            glide_rem_q <= glide_rem_q - RAMP_W'(1);
          end
          tap_cnt_q <= '0;
          state_q   <= ST_RD;
        end
        ST_RD: begin
          tap_zero_q <= tap_zero;
          tap_vld_q  <= tap_vld;
          if (tap_cnt_q != '0) begin
            taps_q[tap_cnt_q[1:0] - 2'd1] <= tap_zero_q ? x_q :
                                             (tap_vld_q ? rd_data_q : '0);
          end
          tap_cnt_q <= tap_cnt_q + 3'd1;
          if (tap_cnt_q == 3'd4) state_q <= ST_M1;
        end
        ST_M1: begin
          mul_q <= prod;
          unique case (mode_q)
            MODE_NONE: begin
              y_q     <= taps_q[1];
              state_q <= ST_OUT;
            end
            MODE_LINEAR: state_q <= ST_L2;
            default:     state_q <= ST_C2;
          endcase
        end
        ST_L2: begin
          y_q     <= sat(lin_y);
          state_q <= ST_OUT;
        end
        ST_C2: begin
          mul_q   <= prod;
          state_q <= ST_C3;
        end
        ST_C3: begin
          mul_q   <= prod;
          state_q <= ST_C4;
        end
        ST_C4: begin
          y_q     <= sat(cub_y);
          state_q <= ST_OUT;
        end
        ST_OUT: begin
          if (!m_axis_tvalid_o || m_axis_tready_i) begin
            m_axis_tvalid_o <= 1'b1;
            m_axis_tdata_o  <= TW'($unsigned(y_q));
            if (wp_q == AW'(DEPTH - 1)) begin
              wp_q      <= '0;
              wrapped_q <= 1'b1;
            end else begin
              wp_q <= wp_q + AW'(1);
            end
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> !s_axis_tready_o)
    else $error("input taken while busy");
  a_wp_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wp_q < AW'(DEPTH - 1) || wp_q == AW'(DEPTH - 1))
    else $error("write position out of range");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=> (m_axis_tvalid_o && $stable(m_axis_tdata_o)))
    else $error("output word changed while waiting");
  a_delay_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RD) |-> (cur_q[CDW-1:16] != '0))
    else $error("delay below one sample at tap read");
`endif

endmodule
`default_nettype wire
